>>> src/fixed_point_atan2_macros.svh
// Assertion macros for the fixed-point arctangent block.
// Included by the top level; the including scope must declare clock and reset.
`ifndef FIXED_POINT_ATAN2_MACROS_SVH
`define FIXED_POINT_ATAN2_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPA_CHECK(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fixed_point_atan2 check failed");

// The consequent must hold in the cycle after the antecedent.
`define FPA_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fixed_point_atan2 check failed");

`endif

>>> src/fpa_pkg.sv
// Shared types and constants for the fixed-point arctangent pipeline.
// No dependencies.
package fpa_pkg;

   // Angles, a full turn being 2^24.
   localparam logic [23:0] ANG_ZERO   = 24'h000000;
   localparam logic [23:0] ANG_EIGHTH = 24'h200000;
   localparam logic [23:0] ANG_QUART  = 24'h400000;
   localparam logic [23:0] ANG_FIVE8  = 24'hA00000;
   localparam logic [23:0] ANG_HALF   = 24'h800000;
   localparam logic [23:0] ANG_THREEQ = 24'hC00000;

   // Approximation constants in Q23: base term and slope (177 * 32).
   localparam logic [21:0] KBASE  = 22'd2826110;
   localparam logic [12:0] KSLOPE = 13'd5664;

   // Control that travels alongside each word.
   typedef struct packed {
      logic        valid;
      logic        eq;      // components equal: angle is the base alone
      logic        sub;     // subtract the arctangent from the base
      logic        qneg;    // ratio is negative
      logic [23:0] base;    // rotation or fixed angle
   } fpa_ctl_type;

   // Divider working set: partial remainder, divisor and quotient so far.
   typedef struct packed {
      logic [17:0] rem;
      logic [16:0] den;
      logic [7:0]  quot;
   } fpa_div_type;

endpackage

>>> src/fpa_channels.sv
// Handshake interfaces for the request and response channels.
// No dependencies.
interface fpa_req_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] y_value;
   logic signed [16:0] x_value;
   modport source (output valid, y_value, x_value, input ready);
   modport sink   (input valid, y_value, x_value, output ready);
endinterface

interface fpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] angle;
   modport source (output valid, angle, input ready);
   modport sink   (input valid, angle, output ready);
endinterface

>>> src/fpa_front.sv
// First stage: magnitudes, octant choice, special cases and divider set-up.
// Depends on fpa_pkg.
module fpa_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic signed [16:0]  y_value,
   input  logic signed [16:0]  x_value,
   output fpa_pkg::fpa_ctl_type ctl_out,
   output fpa_pkg::fpa_div_type div_out
);
   import fpa_pkg::*;

   logic [16:0] ay;
   logic [16:0] ax;
   logic        x_wins;
   fpa_ctl_type ctl_in, ctl_ff;
   fpa_div_type div_in, div_ff;

   // Magnitudes; -65536 maps to 65536, which still fits unsigned.
   assign ay = y_value[16] ? unsigned'(~y_value + 17'sd1) : unsigned'(y_value);
   assign ax = x_value[16] ? unsigned'(~x_value + 17'sd1) : unsigned'(x_value);
   assign x_wins = ax > ay;

   // Choose the octant, its rotation and the division operands.
   always_comb begin
      ctl_in.valid = in_valid;
      ctl_in.eq    = (x_value == y_value);
      if (ctl_in.eq) begin
         ctl_in.sub  = 1'b0;
         ctl_in.qneg = 1'b0;
         if (y_value == 17'sd0) begin
            ctl_in.base = ANG_ZERO;
         end else if (y_value[16]) begin
            ctl_in.base = ANG_FIVE8;
         end else begin
            ctl_in.base = ANG_EIGHTH;
         end
         div_in.rem = {1'b0, ay};
         div_in.den = ax;
      end else if (x_wins) begin
         ctl_in.sub  = 1'b0;
         ctl_in.qneg = y_value[16] ^ x_value[16];
         ctl_in.base = x_value[16] ? ANG_HALF : ANG_ZERO;
         div_in.rem  = {1'b0, ay};
         div_in.den  = ax;
      end else begin
         ctl_in.sub  = 1'b1;
         ctl_in.qneg = y_value[16] ^ x_value[16];
         ctl_in.base = y_value[16] ? ANG_THREEQ : ANG_QUART;
         div_in.rem  = {1'b0, ax};
         div_in.den  = ay;
      end
      div_in.quot = 8'd0;
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctl_ff <= ctl_in;
         div_ff <= div_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign div_out = div_ff;

endmodule

>>> src/fpa_div_stage.sv
// One divider stage: two restoring steps of the smaller-over-larger ratio.
// Depends on fpa_pkg.
module fpa_div_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  fpa_pkg::fpa_ctl_type ctl_in,
   input  fpa_pkg::fpa_div_type div_in,
   output fpa_pkg::fpa_ctl_type ctl_out,
   output fpa_pkg::fpa_div_type div_out
);
   import fpa_pkg::*;

   fpa_ctl_type ctl_ff;
   fpa_div_type div_step_in, div_ff;

   // Each step yields one quotient bit, most significant first. The partial
   // remainder stays below the divisor after a step, so 17 bits hold it
   // before the shift.
   always_comb begin
      logic [17:0] r;
      logic [7:0]  q;
      r = div_in.rem;
      q = div_in.quot;
      for (int i = 0; i < 2; i++) begin
         if (r >= {1'b0, div_in.den}) begin
            r = r - {1'b0, div_in.den};
            q = {q[6:0], 1'b1};
         end else begin
            q = {q[6:0], 1'b0};
         end
         r = {r[16:0], 1'b0};
      end
      div_step_in.rem  = r;
      div_step_in.den  = div_in.den;
      div_step_in.quot = q;
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctl_ff <= ctl_in;
         div_ff <= div_step_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign div_out = div_ff;

endmodule

>>> src/fpa_back.sv
// Last two stages: linear arctangent term, product and octant rotation.
// Depends on fpa_pkg.
module fpa_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  fpa_pkg::fpa_ctl_type ctl_in,
   input  logic [7:0]          quot,
   output logic                out_valid,
   output logic [23:0]         angle
);
   import fpa_pkg::*;

   logic [21:0]        sum;
   logic [9:0]         slope_in, slope_ff;
   logic signed [8:0]  ratio_in, ratio_ff;
   fpa_ctl_type        ctl_ff;
   logic signed [19:0] prod;
   logic [23:0]        turn;
   logic [23:0]        angle_in, angle_ff;
   logic               valid_ff;

   // Corrected slope, base minus the magnitude term, kept to whole 2^-11 steps.
   assign sum      = KBASE - 22'(KSLOPE * quot);
   assign slope_in = sum[21:12];
   assign ratio_in = ctl_in.qneg ? -signed'({1'b0, quot}) : signed'({1'b0, quot});

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctl_ff   <= ctl_in;
         slope_ff <= slope_in;
         ratio_ff <= ratio_in;
      end
   end

   // Slope times ratio (q * 32 in Q23), then rotate modulo a full turn.
   assign prod = signed'({1'b0, slope_ff}) * ratio_ff;
   assign turn = {prod[18:0], 5'b00000};

   always_comb begin
      if (ctl_ff.eq) begin
         angle_in = ctl_ff.base;
      end else if (ctl_ff.sub) begin
         angle_in = ctl_ff.base - turn;
      end else begin
         angle_in = ctl_ff.base + turn;
      end
   end

   // Output register, held while the result word waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= ctl_ff.valid;
         angle_ff <= angle_in;
      end
   end

   assign out_valid = valid_ff;
   assign angle     = angle_ff;

endmodule

>>> src/fixed_point_atan2.sv
// Top level of the fixed-point arctangent pipeline.
// Depends on fpa_pkg, fpa_channels, fpa_front, fpa_div_stage, fpa_back and the macros header.
//
//  channel       dir  word contents
//  req_channel   in   y_value[16:0] signed, x_value[16:0] signed
//  rsp_channel   out  angle[23:0], full turn = 2^24
//
// One word is taken every cycle, barring stalls; each result passes through
// every stage below before it appears on the response channel.
// The pipeline holds the eight restoring division steps, two per stage
// over four stages, plus the set-up stage and two stages of product and rotation.
// Reset is synchronous and clears only the valid bits.
// When a result word is not taken the whole pipeline holds and req ready drops.
module fixed_point_atan2 (
   input logic        clock,
   input logic        reset,
   fpa_req_if.sink    req_channel,
   fpa_rsp_if.source  rsp_channel
);
   import fpa_pkg::*;
   `include "fixed_point_atan2_macros.svh"

   logic        stall;
   logic        enable;
   fpa_ctl_type ctl_chain [0:4];
   fpa_div_type div_chain [0:4];

   // Global hold while the output word waits.
   assign stall             = rsp_channel.valid && !rsp_channel.ready;
   assign enable            = !stall;
   assign req_channel.ready = enable;

   fpa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (req_channel.valid),
      .y_value  (req_channel.y_value),
      .x_value  (req_channel.x_value),
      .ctl_out  (ctl_chain[0]),
      .div_out  (div_chain[0])
   );

   // Four divider stages in a chain.
   for (genvar g = 0; g < 4; g++) begin : g_div
      fpa_div_stage u_div (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .ctl_in  (ctl_chain[g]),
         .div_in  (div_chain[g]),
         .ctl_out (ctl_chain[g + 1]),
         .div_out (div_chain[g + 1])
      );
   end

   fpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .ctl_in    (ctl_chain[4]),
      .quot      (div_chain[4].quot),
      .out_valid (rsp_channel.valid),
      .angle     (rsp_channel.angle)
   );

   // A real division never sees a zero divisor.
   `FPA_CHECK(a_den_nonzero, ctl_chain[0].valid && !ctl_chain[0].eq, div_chain[0].den != 17'd0)
   // The ratio of smaller to larger never exceeds one.
   `FPA_CHECK(a_quot_bound, ctl_chain[4].valid && !ctl_chain[4].eq, div_chain[4].quot <= 8'd128)
   // A stalled output freezes the pipeline behind it.
   `FPA_CHECK_NEXT(a_stall_holds, stall, $stable(div_chain[4]) && $stable(ctl_chain[4]))

endmodule
